>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop)
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

>>> rtl/hscd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscd_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package hscd_pkg;

	localparam int CHANNELS  = 3;
	localparam int BIN_COUNT = 256;
	localparam int BIN_W     = 8;   // bin index
	localparam int CNT_W     = 24;  // bin count
	localparam int SUM_W     = 26;  // difference sum and threshold
	localparam int IDX_W     = 24;  // frame index

	localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] THRESH_RESET = 26'd1000000;

	// controller -> datapath
	typedef struct packed {
		logic             pix_req;     // pixel taken this cycle
		logic             sweep_rd;    // read bin sweep_idx of all stores
		logic             sweep_zero;  // clear current bin sweep_idx
		logic             sweep_cmp;   // copy to previous and feed the difference sum
		logic [BIN_W-1:0] sweep_idx;
		logic             acc_clear;
		logic             result_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
		logic out_full;
	} status_t;

endpackage

>>> rtl/hscd_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscd_bank
// One color channel: current and previous 256-bin histogram memories,
// pixel read-modify-write with write forwarding, and the frame-end sweep.
// ----------------------------------------------------------------------------
module hscd_bank
	import hscd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [BIN_W-1:0] pix_bin,
	output logic [CNT_W-1:0] cur_rd_q,
	output logic [CNT_W-1:0] prev_rd_q
);

	logic [CNT_W-1:0] cur_mem  [BIN_COUNT];
	logic [CNT_W-1:0] prev_mem [BIN_COUNT];

	logic             pix_s1;
	logic [BIN_W-1:0] bin_s1;
	logic             fwd_v_q;
	logic [BIN_W-1:0] fwd_bin_q;
	logic [CNT_W-1:0] fwd_cnt_q;
	logic             copy_s1;
	logic [BIN_W-1:0] copy_idx_s1;

	logic [BIN_W-1:0] rd_addr;
	logic             rd_en;
	logic [CNT_W-1:0] base_cnt;
	logic [CNT_W-1:0] inc_cnt;
	logic             cur_we;
	logic [BIN_W-1:0] cur_wa;
	logic [CNT_W-1:0] cur_wd;

	// read address: pixel bin or sweep position
	assign rd_en   = cmd.pix_req | cmd.sweep_rd;
	assign rd_addr = cmd.pix_req ? pix_bin : cmd.sweep_idx;

	// forward the count written in the same cycle this read was issued
	assign base_cnt = (fwd_v_q && (fwd_bin_q == bin_s1)) ? fwd_cnt_q : cur_rd_q;
	assign inc_cnt  = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + 1'b1;

	// current store write port: increment or sweep clear
	always_comb begin
		cur_we = 1'b0;
		cur_wa = cmd.sweep_idx;
		cur_wd = '0;
		if (pix_s1) begin
			cur_we = 1'b1;
			cur_wa = bin_s1;
			cur_wd = inc_cnt;
		end else if (cmd.sweep_zero) begin
			cur_we = 1'b1;
		end
	end

	// current store, read-first
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_rd_q <= cur_mem[rd_addr];
		end
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
	end

	// previous store
	always_ff @(posedge clk) begin
		if (cmd.sweep_rd) begin
			prev_rd_q <= prev_mem[cmd.sweep_idx];
		end
		if (copy_s1) begin
			prev_mem[copy_idx_s1] <= cur_rd_q;
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1  <= 1'b0;
			fwd_v_q <= 1'b0;
			copy_s1 <= 1'b0;
		end else begin
			pix_s1  <= cmd.pix_req;
			fwd_v_q <= pix_s1;
			copy_s1 <= cmd.sweep_rd & cmd.sweep_cmp;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		bin_s1      <= pix_bin;
		fwd_bin_q   <= bin_s1;
		fwd_cnt_q   <= inc_cnt;
		copy_idx_s1 <= cmd.sweep_idx;
	end

endmodule

>>> rtl/hscd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscd_datapath
// Three channel banks, the bin difference pipeline, the saturating
// accumulator, the threshold register and the result register.
// ----------------------------------------------------------------------------
module hscd_datapath
	import hscd_pkg::*;
#(
	parameter logic [SUM_W-1:0] SUM_CAP = 26'h3FFFFFF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	output status_t                        status,
	input  logic [CHANNELS-1:0][BIN_W-1:0] pix_bins,
	input  logic                           cfg_we,
	input  logic [SUM_W-1:0]               cfg_wdata,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [IDX_W-1:0]               res_index,
	output logic [SUM_W-1:0]               res_sum,
	output logic                           res_cut
);

	logic [CHANNELS-1:0][CNT_W-1:0] cur_rd;
	logic [CHANNELS-1:0][CNT_W-1:0] prev_rd;
	logic [CHANNELS-1:0][CNT_W-1:0] diff_s2;
	logic [CHANNELS-1:0][CNT_W-1:0] diff_d;

	logic             v_s1, v_s2, v_s3;
	logic [SUM_W-1:0] sum3_s3;
	logic [SUM_W-1:0] sum3_d;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W:0]   acc_sum;
	logic [SUM_W-1:0] acc_d;
	logic [SUM_W-1:0] thresh_q;
	logic [IDX_W-1:0] frames_q;
	logic             out_v_q;

	// channel banks
	for (genvar c = 0; c < CHANNELS; c++) begin : g_bank
		hscd_bank u_bank (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.pix_bin   (pix_bins[c]),
			.cur_rd_q  (cur_rd[c]),
			.prev_rd_q (prev_rd[c])
		);
	end

	// absolute bin differences
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			diff_d[c] = (prev_rd[c] > cur_rd[c]) ? prev_rd[c] - cur_rd[c]
			                                     : cur_rd[c] - prev_rd[c];
		end
	end

	// sum over channels
	assign sum3_d = SUM_W'(diff_s2[0]) + SUM_W'(diff_s2[1]) + SUM_W'(diff_s2[2]);

	// saturating accumulate
	assign acc_sum = {1'b0, acc_q} + {1'b0, sum3_s3};
	assign acc_d   = (acc_sum > {1'b0, SUM_CAP}) ? SUM_CAP : acc_sum[SUM_W-1:0];

	// sweep pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.sweep_rd & cmd.sweep_cmp;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// sweep pipeline payload
	always_ff @(posedge clk) begin
		diff_s2 <= diff_d;
		sum3_s3 <= sum3_d;
	end

	// accumulator, threshold, frame counter, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			thresh_q  <= THRESH_RESET;
			frames_q  <= '0;
			out_v_q   <= 1'b0;
			res_index <= '0;
			res_sum   <= '0;
			res_cut   <= 1'b0;
		end else begin
			if (cmd.acc_clear) begin
				acc_q <= '0;
			end else if (v_s3) begin
				acc_q <= acc_d;
			end
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (cmd.result_load) begin
				frames_q  <= frames_q + 1'b1;
				res_index <= frames_q + 1'b1;
				res_sum   <= acc_q;
				res_cut   <= (acc_q > thresh_q);
				out_v_q   <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign res_valid        = out_v_q;
	assign status.pipe_busy = v_s1 | v_s2 | v_s3;
	assign status.out_full  = out_v_q;

endmodule

>>> rtl/hscd_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// hscd_ctrl
// Sequencer: clearing pass after reset, pixel intake, frame-end sweep,
// pipeline flush and result hand-off.
// ----------------------------------------------------------------------------
module hscd_ctrl
	import hscd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAIN,
		ST_SWEEP,
		ST_FLUSH,
		ST_REPORT
	} state_t;

	localparam logic [BIN_W-1:0] LastBin = BIN_W'(BIN_COUNT - 1);

	state_t           state_q;
	logic [BIN_W-1:0] cnt_q;
	logic             have_prev_q;
	logic             in_acc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;

	// commands decoded from state
	always_comb begin
		cmd             = '0;
		cmd.pix_req     = in_acc;
		cmd.sweep_idx   = cnt_q;
		cmd.sweep_rd    = (state_q == ST_CLEAR) || (state_q == ST_SWEEP);
		cmd.sweep_zero  = cmd.sweep_rd;
		cmd.sweep_cmp   = (state_q == ST_SWEEP);
		cmd.acc_clear   = (state_q == ST_DRAIN);
		cmd.result_load = (state_q == ST_REPORT) && have_prev_q && !status.out_full;
	end

	// state, sweep counter, first-frame flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			have_prev_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastBin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && in_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last pixel's increment lands this cycle
					cnt_q   <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastBin) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!status.pipe_busy) begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (!have_prev_q) begin
						have_prev_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (!status.out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// frame end always enters the drain cycle before any sweep read
	`ASSERT_NEXT(a_end_drain, clk, arst_n, in_acc && in_last, state_q == ST_DRAIN)
	// the result register is never overwritten
	`ASSERT_SAME(a_load_free, clk, arst_n, cmd.result_load, !status.out_full)
	// the sum is read only after the difference pipeline has emptied
	`ASSERT_SAME(a_report_flushed, clk, arst_n, state_q == ST_REPORT, !status.pipe_busy)

endmodule

>>> rtl/histogram_shot_cut_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_shot_cut_detector
// Shot-cut detection by per-frame color histogram difference.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit up)
// s_*       in   tdata: comp_blue[7:0] comp_green[15:8] comp_red[23:16]; tlast: frame_end
// m_*       out  tdata: frame_index[23:0] diff_sum[49:24]; tuser: cut_found
// cfg_*     in   cfg_wdata: cut_threshold[25:0], written when cfg_we is high
//
// Pixels are taken one per cycle while idle; each updates three bins by read-modify-write.
// A frame end adds a sweep over all 256 bins of the bin memories (one bin of all three
// channels per cycle) plus a drain, a flush and a report state, in which no pixel is taken.
// After reset a clearing pass over all bins runs before the first pixel is taken.
// A pending result does not stop pixel intake, but it stalls the next frame end's
// report, and pixel intake resumes only once that report is loaded.
// ----------------------------------------------------------------------------
module histogram_shot_cut_detector
	import hscd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_PIXELS = 8388608
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel requests
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // comp_blue, comp_green, comp_red
	input  logic                  s_tlast,   // frame_end
	// results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,   // frame_index, diff_sum, zero fill
	output logic                  m_tuser,   // cut_found
	// threshold register
	input  logic                  cfg_we,
	input  logic [SUM_W-1:0]      cfg_wdata
);

	localparam longint unsigned SumRaw = 64'(6) * 64'(MAX_FRAME_PIXELS);
	localparam logic [SUM_W-1:0] SumCap =
		(SumRaw > 64'h3FFFFFF) ? 26'h3FFFFFF : SUM_W'(SumRaw);

	cmd_t                           cmd;
	status_t                        status;
	logic [CHANNELS-1:0][BIN_W-1:0] pix_bins;
	logic [IDX_W-1:0]               res_index;
	logic [SUM_W-1:0]               res_sum;

	// split pixel components
	assign pix_bins[0] = s_tdata[7:0];
	assign pix_bins[1] = s_tdata[15:8];
	assign pix_bins[2] = s_tdata[23:16];

	hscd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	hscd_datapath #(
		.SUM_CAP (SumCap)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pix_bins  (pix_bins),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_index (res_index),
		.res_sum   (res_sum),
		.res_cut   (m_tuser)
	);

	// pack result
	assign m_tdata = {6'd0, res_sum, res_index};

endmodule

>>> tb/histogram_shot_cut_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_shot_cut_detector_tb
// Streams pixel frames into the shot-cut detector under random idling and
// back-pressure, keeps its own copy of the per-frame histograms, and checks
// every reported frame index, difference sum and cut flag in order.
// ----------------------------------------------------------------------------
module histogram_shot_cut_detector_tb;
	import hscd_pkg::*;

	localparam int unsigned MAX_FRAME_PIXELS = 8388608;
	localparam longint unsigned SUM_FIELD_MAX = (64'd1 << SUM_W) - 1;
	localparam longint unsigned SUM_CAP = (64'd6 * MAX_FRAME_PIXELS > SUM_FIELD_MAX) ?
		SUM_FIELD_MAX : 64'd6 * MAX_FRAME_PIXELS;
	localparam logic [SUM_W-1:0] THRESH_TOP = 26'd50331648;
	localparam int NBINS         = CHANNELS * BIN_COUNT;
	localparam int SETTLE_CYCLES = 300;      // frame-end sweep, drain, flush and report
	localparam int HOLD_CYCLES   = 3000;     // long receiver hold-off
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic       last;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [SUM_W-1:0] diff;
		logic             cut;
	} cut_report_t;

	typedef enum {FRAME_NOISE, FRAME_PALETTE, FRAME_REPEAT, FRAME_TOUCHED} frame_kind_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [23:0]      s_tdata   = '0;
	logic             s_tlast   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [55:0]      m_tdata;
	logic             m_tuser;
	logic             cfg_we    = 1'b0;
	logic [SUM_W-1:0] cfg_wdata = '0;

	// predicted block state
	logic [CNT_W-1:0] cur_bins  [NBINS];
	logic [CNT_W-1:0] prev_bins [NBINS];
	logic [IDX_W-1:0] frames_done;
	logic             have_prev;
	logic [SUM_W-1:0] cut_level;

	pixel_t      pixel_queue[$];
	cut_report_t report_queue[$];
	pixel_t      last_frame[$];

	logic send_idle    = 1'b1;
	logic recv_idle    = 1'b1;
	logic hold_armed   = 1'b0;
	logic hold_started = 1'b0;
	int   hold_left    = 0;
	int   error_count  = 0;
	int   cycle_count  = 0;

	histogram_shot_cut_detector uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// count one accepted pixel; at a frame end compare against the previous frame
	task automatic count_pixel(input pixel_t px);
		int              idx;
		longint unsigned total;
		cut_report_t     rep;
		logic [7:0]      comp [CHANNELS];
		comp[0] = px.blue;
		comp[1] = px.green;
		comp[2] = px.red;
		for (int c = 0; c < CHANNELS; c++) begin
			idx = c * BIN_COUNT + int'(comp[c]);
			if (cur_bins[idx] != CNT_MAX)
				cur_bins[idx] = cur_bins[idx] + 1'b1;
		end
		if (px.last) begin
			if (have_prev) begin
				total = 0;
				for (int i = 0; i < NBINS; i++)
					total += (prev_bins[i] > cur_bins[i]) ?
						prev_bins[i] - cur_bins[i] : cur_bins[i] - prev_bins[i];
				if (total > SUM_CAP)
					total = SUM_CAP;
				frames_done = frames_done + 1'b1;
				rep.index = frames_done;
				rep.diff  = total[SUM_W-1:0];
				rep.cut   = (total > longint'(cut_level));
				report_queue.push_back(rep);
			end
			prev_bins = cur_bins;
			foreach (cur_bins[i])
				cur_bins[i] = '0;
			have_prev = 1'b1;
		end
	endtask

	task automatic note_failure(input string msg);
		if (error_count < REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// pixel driver: takes the next request when the bus is free
	always @(posedge clk) begin : drive_pixels
		pixel_t px;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				count_pixel(pixel_t'({s_tlast, s_tdata}));
			if (!s_tvalid || s_tready) begin
				if (pixel_queue.size() != 0 && (!send_idle || $urandom_range(99) >= 20)) begin
					px = pixel_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= px[23:0];
					s_tlast  <= px.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver: random idling, one long hold-off when armed
	always @(posedge clk) begin
		if (hold_armed && !hold_started) begin
			hold_started <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= !recv_idle || ($urandom_range(99) >= 20);
		end
	end

	// result monitor
	always @(posedge clk) begin : check_reports
		cut_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (report_queue.size() == 0) begin
				note_failure($sformatf("unexpected result index %0d diff %0d cut %0b",
					m_tdata[23:0], m_tdata[49:24], m_tuser));
			end else begin
				want = report_queue.pop_front();
				if (m_tdata[23:0] !== want.index || m_tdata[49:24] !== want.diff ||
						m_tuser !== want.cut)
					note_failure($sformatf("index %0d/%0d diff %0d/%0d cut %0b/%0b (exp/act)",
						want.index, m_tdata[23:0], want.diff, m_tdata[49:24],
						want.cut, m_tuser));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** histogram_shot_cut_detector: FAILED **");
			$finish;
		end
	end

	function automatic pixel_t rand_pixel();
		pixel_t px;
		px.last  = 1'b0;
		px.blue  = 8'($urandom);
		px.green = 8'($urandom);
		px.red   = 8'($urandom);
		return px;
	endfunction

	task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic last);
		pixel_t px;
		px.blue  = b;
		px.green = g;
		px.red   = r;
		px.last  = last;
		pixel_queue.push_back(px);
	endtask

	// one well-formed frame: noise, few colors, repeat or near-repeat of the last one
	task automatic add_frame(input int len, output int pushed);
		frame_kind_t kind;
		pixel_t      palette [2];
		pixel_t      built[$];
		pixel_t      px;
		kind = frame_kind_t'($urandom_range(3));
		if ((kind == FRAME_REPEAT || kind == FRAME_TOUCHED) && last_frame.size() == 0)
			kind = FRAME_NOISE;
		palette[0] = rand_pixel();
		palette[1] = rand_pixel();
		if (kind == FRAME_REPEAT || kind == FRAME_TOUCHED) begin
			built = last_frame;
		end else begin
			for (int i = 0; i < len; i++)
				built.push_back(kind == FRAME_NOISE ? rand_pixel() : palette[$urandom_range(1)]);
		end
		if (kind == FRAME_TOUCHED)
			built[$urandom_range(built.size() - 1)] = rand_pixel();
		foreach (built[i]) begin
			px      = built[i];
			px.last = (i == built.size() - 1);
			built[i] = px;
			pixel_queue.push_back(px);
		end
		last_frame = built;
		pushed = built.size();
	endtask

	task automatic fill_random(input int n);
		int added;
		int len;
		int pushed;
		added = 0;
		while (added < n) begin
			len = ($urandom_range(15) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
			add_frame(len, pushed);
			added += pushed;
		end
	endtask

	// all requests taken, all results seen, frame-end sweep finished
	task automatic wait_drained();
		do @(negedge clk);
		while (pixel_queue.size() != 0 || s_tvalid || report_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [SUM_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cut_level = value;
	endtask

	// stimulus sequence
	initial begin
		foreach (cur_bins[i]) begin
			cur_bins[i]  = '0;
			prev_bins[i] = '0;
		end
		frames_done = '0;
		have_prev   = 1'b0;
		cut_level   = THRESH_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset threshold: first frame silent, then extremes and an exact repeat
		@(negedge clk);
		push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		push_pixel(8'h55, 8'hAA, 8'h0F, 1'b0);
		push_pixel(8'hAA, 8'h55, 8'hF0, 1'b1);
		push_pixel(8'h55, 8'hAA, 8'h0F, 1'b0);
		push_pixel(8'hAA, 8'h55, 8'hF0, 1'b1);
		wait_drained();

		// threshold 2: sum equal to threshold is no cut, one above is
		write_threshold(26'd2);
		@(negedge clk);
		push_pixel(8'd1, 8'd2, 8'd3, 1'b1);
		push_pixel(8'd1, 8'd2, 8'd4, 1'b1);
		push_pixel(8'd0, 8'd2, 8'd5, 1'b1);
		push_pixel(8'd0, 8'd2, 8'd5, 1'b1);
		push_pixel(8'd7, 8'd7, 8'd7, 1'b0);
		push_pixel(8'd7, 8'd7, 8'd7, 1'b1);
		push_pixel(8'h80, 8'h01, 8'hFE, 1'b0);
		push_pixel(8'h7F, 8'hFE, 8'h01, 1'b1);
		wait_drained();

		// zero threshold, no idling on either side
		write_threshold('0);
		@(negedge clk);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		fill_random(250);
		wait_drained();

		// top threshold, receiver holds off so the input backs up
		write_threshold(THRESH_TOP);
		@(negedge clk);
		send_idle  = 1'b1;
		recv_idle  = 1'b1;
		hold_armed = 1'b1;
		fill_random(200);

		for (int p = 0; p < 5; p++) begin
			wait_drained();
			if (p == 0)
				write_threshold(26'hFFFFFF);
			else if (p == 2)
				write_threshold(SUM_W'($urandom_range(0, THRESH_TOP)));
			else
				write_threshold(SUM_W'($urandom_range(60)));
			@(negedge clk);
			fill_random(175);
		end
		wait_drained();

		if (error_count == 0 && report_queue.size() == 0) begin
			$display("** histogram_shot_cut_detector: PASSED **");
		end else begin
			$display("** histogram_shot_cut_detector: FAILED **");
		end
		$finish;
	end

endmodule
